/* sv/radix_prefixed_number_parser_macros.svh */
// Assertion macros for the radix-prefixed number parser.
// Assumes the including module has clk_i and rst_ni (active low) in scope.
`ifndef RADIX_PREFIXED_NUMBER_PARSER_MACROS_SVH
`define RADIX_PREFIXED_NUMBER_PARSER_MACROS_SVH

// Check a property on every rising clock edge outside of reset
`define RPNP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check that a condition never holds outside of reset
`define RPNP_ASSERT_NEVER(label, cond, msg) \
  `RPNP_ASSERT(label, !(cond), msg)

`endif

/* sv/rpnp_pkg.sv */
// Shared types, constants and digit decode for the radix-prefixed number parser.
// No dependencies.
package rpnp_pkg;

  localparam int unsigned CELL_BITS_DEF = 32;
  localparam int unsigned CHAR_W        = 8;
  localparam int unsigned BASE_W        = 5;
  localparam int unsigned VALUE_W       = 32;

  localparam logic [BASE_W-1:0] BASE_RST = BASE_W'(10);
  localparam logic [BASE_W-1:0] BASE_BIN = BASE_W'(2);
  localparam logic [BASE_W-1:0] BASE_DEC = BASE_W'(10);
  localparam logic [BASE_W-1:0] BASE_HEX = BASE_W'(16);

  // Marks a character that is no hex digit; above any legal base
  localparam logic [BASE_W-1:0] DIGIT_NONE = '1;

  localparam logic [CHAR_W-1:0] CH_PERCENT = 8'h25;
  localparam logic [CHAR_W-1:0] CH_HASH    = 8'h23;
  localparam logic [CHAR_W-1:0] CH_DOLLAR  = 8'h24;
  localparam logic [CHAR_W-1:0] CH_MINUS   = 8'h2d;
  localparam logic [CHAR_W-1:0] CH_0       = 8'h30;
  localparam logic [CHAR_W-1:0] CH_9       = 8'h39;
  localparam logic [CHAR_W-1:0] CH_LC_A    = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LC_F    = 8'h66;
  localparam logic [CHAR_W-1:0] CH_UC_A    = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UC_F    = 8'h46;

  // Where the word stands: before prefixes, after '%', after '#', in the digits
  typedef enum logic [3:0] {
    PH_START  = 4'b0001,
    PH_PCT    = 4'b0010,
    PH_HASH   = 4'b0100,
    PH_DIGITS = 4'b1000
  } phase_e;

  // Hex digit value of a character, DIGIT_NONE for anything else
  function automatic logic [BASE_W-1:0] digit_of(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] d;
    d = '0;
    if (c >= CH_0 && c <= CH_9) begin
      d = c - CH_0;
    end else if (c >= CH_LC_A && c <= CH_LC_F) begin
      d = c - CH_LC_A + CHAR_W'(10);
    end else if (c >= CH_UC_A && c <= CH_UC_F) begin
      d = c - CH_UC_A + CHAR_W'(10);
    end else begin
      return DIGIT_NONE;
    end
    return d[BASE_W-1:0];
  endfunction

endpackage

/* sv/radix_prefixed_number_parser.sv */
// Radix-prefixed number parser: ASCII word in, one signed integer per word out.
// Depends on rpnp_pkg and radix_prefixed_number_parser_macros.svh.
//
//   channel | direction | handshake                 | payload
//   --------+-----------+---------------------------+-----------------------------
//   cfg     | in        | cfg_valid_i / cfg_ready_o | default_base_i
//   in      | in        | in_valid_i  / in_ready_o  | char_code_i, last_char_i
//   out     | out       | out_valid_o / out_ready_i | valid_res_o, value_o
//
// One character a cycle unless a last character waits on a full result register: a
// beat lands in the input register, then the digit multiply-add updates the word
// state and, on the last character, loads the result register. A word's last beat
// passes the input register, then the result register, which drives out_valid_o.
// Reset clears the word state and sets the default base to 10.
// A result waiting in the output register stalls only a following last
// character; other characters keep flowing.
`include "radix_prefixed_number_parser_macros.svh"

module radix_prefixed_number_parser
  import rpnp_pkg::*;
#(
  parameter int unsigned CELL_BITS = CELL_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [BASE_W-1:0]         default_base_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [CHAR_W-1:0]         char_code_i,
  input  logic                      last_char_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic                      valid_res_o,
  output logic signed [VALUE_W-1:0] value_o
);

  logic [BASE_W-1:0]    default_base_q;
  logic                 in_valid_q;
  logic [CHAR_W-1:0]    char_q;
  logic                 last_q;
  phase_e               phase_q, phase_d;
  logic [BASE_W-1:0]    base_q, base_d, base;
  logic [CELL_BITS-1:0] acc_q, acc_d;
  logic                 neg_q, neg_d;
  logic                 err_q, err_d;
  logic [BASE_W-1:0]    digit;
  logic                 proc;
  logic                 out_valid_q;
  logic                 res_valid_q;
  logic [VALUE_W-1:0]   res_value_q, res_value_d;
  logic [CELL_BITS-1:0] word_v;

  // Config register, always writable
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      default_base_q <= BASE_RST;
    end else if (cfg_valid_i) begin
      default_base_q <= default_base_i;
    end
  end

  // Process the held beat unless it finishes a word and the result slot is full and not being taken
  assign proc       = in_valid_q && (!last_q || !out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || proc;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      char_q <= char_code_i;
      last_q <= last_char_i;
    end
  end

  // Classify the character and advance the word state
  always_comb begin
    base    = (phase_q == PH_START) ? default_base_q : base_q;
    digit   = digit_of(char_q);
    phase_d = phase_q;
    base_d  = base;
    acc_d   = acc_q;
    neg_d   = neg_q;
    err_d   = err_q;
    if (!err_q) begin
      priority if (phase_q == PH_START && char_q == CH_PERCENT) begin
        base_d  = BASE_BIN;
        phase_d = PH_PCT;
      end else if ((phase_q == PH_START || phase_q == PH_PCT) && char_q == CH_HASH) begin
        base_d  = BASE_DEC;
        phase_d = PH_HASH;
      end else if (phase_q != PH_DIGITS && char_q == CH_DOLLAR) begin
        base_d  = BASE_HEX;
        phase_d = PH_DIGITS;
      end else if (phase_q != PH_DIGITS && base == BASE_DEC && char_q == CH_MINUS) begin
        neg_d   = 1'b1;
        phase_d = PH_DIGITS;
      end else begin
        phase_d = PH_DIGITS;
        if (digit < base) begin
          acc_d = acc_q * CELL_BITS'(base) + CELL_BITS'(digit);
        end else begin
          err_d = 1'b1;
        end
      end
    end
  end

  // Apply the sign, fit the cell to the result width, and give zero on error
  always_comb begin
    word_v      = neg_d ? (CELL_BITS'(0) - acc_d) : acc_d;
    res_value_d = err_d ? '0 : VALUE_W'($signed(word_v));
  end

  // Word state; a last character starts a fresh word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_START;
      base_q  <= BASE_RST;
      acc_q   <= '0;
      neg_q   <= 1'b0;
      err_q   <= 1'b0;
    end else if (proc) begin
      base_q <= base_d;
      if (last_q) begin
        phase_q <= PH_START;
        acc_q   <= '0;
        neg_q   <= 1'b0;
        err_q   <= 1'b0;
      end else begin
        phase_q <= phase_d;
        acc_q   <= acc_d;
        neg_q   <= neg_d;
        err_q   <= err_d;
      end
    end
  end

  // Result register; hold until the beat is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (proc && last_q) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc && last_q) begin
      res_valid_q <= !err_d;
      res_value_q <= res_value_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign valid_res_o = res_valid_q;
  assign value_o     = $signed(res_value_q);

  `RPNP_ASSERT(a_res_from_last, $rose(out_valid_q) |-> $past(proc && last_q), "orphan result")
  `RPNP_ASSERT_NEVER(a_bad_zero, out_valid_q && !res_valid_q && res_value_q != '0, "bad value")
  `RPNP_ASSERT(a_restart, proc && last_q |=> phase_q == PH_START && !err_q && !neg_q, "no restart")
  `RPNP_ASSERT(a_hold, !in_ready_o |=> in_valid_q && $stable({char_q, last_q}), "held beat lost")

endmodule
